// ===== rtl/jec_pkg.sv =====
// ----------------------------------------------------------------------------
// jec_pkg: shared types and constants of the escape count unit
// Fixed-point widths, register indexes, sequencer states and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

package jec_pkg;

   localparam int FRAC      = 26;
   localparam int MUL_W     = 31;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int RND_W     = PROD_W - FRAC;
   localparam int NXT_W     = RND_W + 1;
   localparam int SQ_W      = 56;
   localparam int MAX_W     = 16;
   localparam int CREG_W    = 29;
   localparam int REG_IDX_W = 2;

   localparam logic signed [CREG_W-1:0] C_LIMIT   = 29'sd134217728;
   localparam logic [SQ_W:0]            FOUR_WIDE = 57'd1 << (2 * FRAC + 2);
   localparam logic [SQ_W:0]            HALF_SQ   = 57'd1 << (FRAC - 1);
   localparam logic signed [PROD_W-1:0] HALF_PROD = 62'sd1 <<< (FRAC - 1);

   localparam logic [MAX_W-1:0]         RESET_MAX  = 16'd255;
   localparam logic signed [CREG_W-1:0] RESET_C_RE = -29'sd43594139;
   localparam logic signed [CREG_W-1:0] RESET_C_IM = -29'sd32049486;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_MAX_ITER   = 2'd0,
      REG_C_REAL     = 2'd1,
      REG_C_IMAG     = 2'd2,
      REG_POWER_MODE = 2'd3
   } reg_idx_type;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_CHECK  = 10'b0000000010,
      ST_SQ_XX  = 10'b0000000100,
      ST_SQ_YY  = 10'b0000001000,
      ST_SQ_XY  = 10'b0000010000,
      ST_P_UU   = 10'b0000100000,
      ST_P_VV   = 10'b0001000000,
      ST_P_UV   = 10'b0010000000,
      ST_UPDATE = 10'b0100000000,
      ST_FINISH = 10'b1000000000
   } state_type;

   // round a product with 2*FRAC fraction bits to FRAC bits, half up
   function automatic logic signed [RND_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] q;
      q = p + HALF_PROD;
      return RND_W'(q >>> FRAC);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/julia_escape_count_unit.sv =====
// ----------------------------------------------------------------------------
// julia_escape_count_unit: Julia set escape-time counter
// Iterates z = z^2 + c or z^4 + c in Q6.26 fixed point from a start point
// and returns the number of steps done before |z| exceeds 2 or the step limit is reached.
// ----------------------------------------------------------------------------
// One start point is taken when req_tready is high and is worked on alone.
// Every product goes through one 31x31 signed multiplier that issues one
// product per cycle, so a step in square mode passes the states check, x*x,
// y*y, x*y and update, and fourth-power mode adds u*u, v*v and u*v before
// update. The result waits in an output register; the next request is taken
// while it waits. Configuration writes belong in idle time; a c value outside
// plus or minus 2.0 is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module julia_escape_count_unit #(
   parameter int COUNT_BITS = 16,
   parameter int COORD_BITS = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   // start_re [COORD_BITS-1:0], start_im [2*COORD_BITS-1:COORD_BITS]
   input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // escape_count [COUNT_BITS-1:0]
   output logic [((COUNT_BITS+7)/8)*8-1:0]               rsp_tdata,
   input  wire logic                                     csr_we,
   input  wire logic [jec_pkg::REG_IDX_W-1:0]            csr_addr,
   input  wire logic [jec_pkg::CREG_W-1:0]               csr_wdata
);

   localparam int OUT_W = ((COUNT_BITS + 7) / 8) * 8;
   localparam int XW    = COORD_BITS > jec_pkg::MUL_W ? COORD_BITS : jec_pkg::MUL_W;
   localparam int SUM_W = COORD_BITS > jec_pkg::NXT_W ? COORD_BITS + 1 : jec_pkg::NXT_W + 1;
   localparam int RU_W  = jec_pkg::SQ_W + 1 - jec_pkg::FRAC;

   jec_pkg::state_type state_ff, state_in;

   logic signed [COORD_BITS-1:0]        x_ff, x_in, y_ff, y_in;
   logic [jec_pkg::MAX_W-1:0]           n_ff, n_in;
   logic [jec_pkg::SQ_W-1:0]            xx_ff, xx_in;
   logic signed [jec_pkg::MUL_W-1:0]    wre_ff, wre_in, wim_ff, wim_in;
   logic signed [jec_pkg::RND_W-1:0]    ruu_ff, ruu_in;
   logic signed [jec_pkg::NXT_W-1:0]    nre_ff, nre_in, nim_ff, nim_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]               rsp_data_ff, rsp_data_in;

   logic [jec_pkg::MAX_W-1:0]           max_ff, max_in;
   logic signed [jec_pkg::CREG_W-1:0]   c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic                                pow_ff, pow_in;

   logic signed [jec_pkg::MUL_W-1:0]    op_a, op_b;
   logic signed [jec_pkg::PROD_W-1:0]   prod_ff;

   logic signed [XW-1:0]                x_ext, y_ext, two_x;
   logic                                out_of_box;
   logic [jec_pkg::SQ_W:0]              mag_sum, rxx_full, ryy_full;
   logic [RU_W-1:0]                     rxx, ryy;
   logic signed [jec_pkg::RND_W-1:0]    rprod;
   logic signed [SUM_W-1:0]             sum_re, sum_im;
   logic signed [jec_pkg::CREG_W-1:0]   csr_c;
   logic                                csr_c_ok;
   logic                                accept;

   function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic ovf;
      ovf = v[SUM_W-1:COORD_BITS-1] != {(SUM_W-COORD_BITS+1){v[SUM_W-1]}};
      if (ovf) begin
         return v[SUM_W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return v[COORD_BITS-1:0];
   endfunction

   jec_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   assign req_tready = state_ff == jec_pkg::ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'(rsp_data_ff);

   assign x_ext      = XW'(x_ff);
   assign y_ext      = XW'(y_ff);
   assign two_x      = XW'(jec_pkg::C_LIMIT);
   assign out_of_box = (x_ext > two_x) || (x_ext < -two_x) ||
                       (y_ext > two_x) || (y_ext < -two_x);

   assign mag_sum  = {1'b0, xx_ff} + {1'b0, prod_ff[jec_pkg::SQ_W-1:0]};
   assign rxx_full = {1'b0, xx_ff} + jec_pkg::HALF_SQ;
   assign ryy_full = {1'b0, prod_ff[jec_pkg::SQ_W-1:0]} + jec_pkg::HALF_SQ;
   assign rxx      = rxx_full[jec_pkg::SQ_W:jec_pkg::FRAC];
   assign ryy      = ryy_full[jec_pkg::SQ_W:jec_pkg::FRAC];
   assign rprod    = jec_pkg::round_q(prod_ff);

   assign sum_re = SUM_W'(nre_ff) + SUM_W'(c_re_ff);
   assign sum_im = SUM_W'(nim_ff) + SUM_W'(c_im_ff);

   assign csr_c    = csr_wdata;
   assign csr_c_ok = (csr_c >= -jec_pkg::C_LIMIT) && (csr_c <= jec_pkg::C_LIMIT);

   always_comb begin
      case (state_ff)
         jec_pkg::ST_SQ_XX: begin
            op_a = y_ext[jec_pkg::MUL_W-1:0];
            op_b = y_ext[jec_pkg::MUL_W-1:0];
         end
         jec_pkg::ST_SQ_YY: begin
            op_a = x_ext[jec_pkg::MUL_W-1:0];
            op_b = y_ext[jec_pkg::MUL_W-1:0];
         end
         jec_pkg::ST_SQ_XY: begin
            op_a = wre_ff;
            op_b = wre_ff;
         end
         jec_pkg::ST_P_UU: begin
            op_a = wim_ff;
            op_b = wim_ff;
         end
         jec_pkg::ST_P_VV: begin
            op_a = wre_ff;
            op_b = wim_ff;
         end
         default: begin
            op_a = x_ext[jec_pkg::MUL_W-1:0];
            op_b = x_ext[jec_pkg::MUL_W-1:0];
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      n_in         = n_ff;
      xx_in        = xx_ff;
      wre_in       = wre_ff;
      wim_in       = wim_ff;
      ruu_in       = ruu_ff;
      nre_in       = nre_ff;
      nim_in       = nim_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         jec_pkg::ST_IDLE: begin
            if (accept) begin
               x_in     = req_tdata[COORD_BITS-1:0];
               y_in     = req_tdata[2*COORD_BITS-1:COORD_BITS];
               n_in     = '0;
               state_in = jec_pkg::ST_CHECK;
            end
         end
         jec_pkg::ST_CHECK: begin
            if (n_ff >= max_ff || out_of_box) begin
               state_in = jec_pkg::ST_FINISH;
            end else begin
               state_in = jec_pkg::ST_SQ_XX;
            end
         end
         jec_pkg::ST_SQ_XX: begin
            xx_in    = prod_ff[jec_pkg::SQ_W-1:0];
            state_in = jec_pkg::ST_SQ_YY;
         end
         jec_pkg::ST_SQ_YY: begin
            wre_in = $signed(jec_pkg::MUL_W'(rxx)) - $signed(jec_pkg::MUL_W'(ryy));
            nre_in = jec_pkg::NXT_W'(wre_in);
            if (mag_sum > jec_pkg::FOUR_WIDE) begin
               state_in = jec_pkg::ST_FINISH;
            end else begin
               state_in = jec_pkg::ST_SQ_XY;
            end
         end
         jec_pkg::ST_SQ_XY: begin
            wim_in   = $signed({rprod[jec_pkg::MUL_W-2:0], 1'b0});
            nim_in   = jec_pkg::NXT_W'(wim_in);
            state_in = pow_ff ? jec_pkg::ST_P_UU : jec_pkg::ST_UPDATE;
         end
         jec_pkg::ST_P_UU: begin
            ruu_in   = rprod;
            state_in = jec_pkg::ST_P_VV;
         end
         jec_pkg::ST_P_VV: begin
            nre_in   = jec_pkg::NXT_W'(ruu_ff) - jec_pkg::NXT_W'(rprod);
            state_in = jec_pkg::ST_P_UV;
         end
         jec_pkg::ST_P_UV: begin
            nim_in   = $signed({rprod, 1'b0});
            state_in = jec_pkg::ST_UPDATE;
         end
         jec_pkg::ST_UPDATE: begin
            x_in     = sat_coord(sum_re);
            y_in     = sat_coord(sum_im);
            n_in     = n_ff + 1'b1;
            state_in = jec_pkg::ST_CHECK;
         end
         jec_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = COUNT_BITS'(n_ff);
               state_in     = jec_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jec_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      max_in = max_ff;
      c_re_in = c_re_ff;
      c_im_in = c_im_ff;
      pow_in = pow_ff;
      if (csr_we) begin
         unique case (csr_addr)
            jec_pkg::REG_MAX_ITER: begin
               max_in = csr_wdata[jec_pkg::MAX_W-1:0];
            end
            jec_pkg::REG_C_REAL: begin
               if (csr_c_ok) begin
                  c_re_in = csr_c;
               end
            end
            jec_pkg::REG_C_IMAG: begin
               if (csr_c_ok) begin
                  c_im_in = csr_c;
               end
            end
            jec_pkg::REG_POWER_MODE: begin
               pow_in = csr_wdata[0];
            end
            default: begin
               pow_in = pow_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jec_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_ff       <= jec_pkg::RESET_MAX;
         c_re_ff      <= jec_pkg::RESET_C_RE;
         c_im_ff      <= jec_pkg::RESET_C_IM;
         pow_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_ff       <= max_in;
         c_re_ff      <= c_re_in;
         c_im_ff      <= c_im_in;
         pow_ff       <= pow_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      n_ff        <= n_in;
      xx_ff       <= xx_in;
      wre_ff      <= wre_in;
      wim_ff      <= wim_in;
      ruu_ff      <= ruu_in;
      nre_ff      <= nre_in;
      nim_ff      <= nim_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== rtl/jec_mul.sv =====
// ----------------------------------------------------------------------------
// jec_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module jec_mul (
   input  wire logic                               clock,
   input  wire logic signed [jec_pkg::MUL_W-1:0]   op_a,
   input  wire logic signed [jec_pkg::MUL_W-1:0]   op_b,
   output logic signed [jec_pkg::PROD_W-1:0]       prod_ff
);

   logic signed [jec_pkg::PROD_W-1:0] prod_in;

   assign prod_in = jec_pkg::PROD_W'(op_a) * jec_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== rtl/jec_checker.sv =====
// ----------------------------------------------------------------------------
// jec_checker: port-level checks of the escape count unit
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module jec_checker #(
   parameter int COUNT_BITS = 16,
   parameter int COORD_BITS = 32
) (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_tvalid,
   input wire logic                                 req_tready,
   input wire logic [((2*COORD_BITS+7)/8)*8-1:0]    req_tdata,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [((COUNT_BITS+7)/8)*8-1:0]      rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request dropped or changed while waiting");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a point is in work");

   a_rsp_from_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result appeared while the sequencer is busy");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset left a result or a busy sequencer");

endmodule

bind julia_escape_count_unit jec_checker #(
   .COUNT_BITS (COUNT_BITS),
   .COORD_BITS (COORD_BITS)
) u_jec_checker (.*);

`default_nettype wire

// ===== tb/julia_escape_count_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// julia_escape_count_unit_tb: self-checking bench for the escape count unit
// Sends start points over the request stream and predicts each escape count
// with a 64-bit fixed-point model of the z^2 + c / z^4 + c iteration. Every
// response is compared in order. Directed points hit the radius boundary,
// rounding ties and coordinate extremes. Register tests cover the zero
// limit, wide writes, dropped c values and the power mode. A back-pressure
// test and randomized sweeps of limit, c and mode follow, with random gaps
// on both sides.
// ----------------------------------------------------------------------------
module julia_escape_count_unit_tb;

   localparam int          COUNT_BITS    = 16;
   localparam int          COORD_BITS    = 32;
   localparam int          CSR_W         = jec_pkg::CREG_W;
   localparam int          FRAC_BITS     = 26;
   localparam longint      Q_ONE         = 64'sd1 <<< FRAC_BITS;
   localparam longint      Q_TWO         = 64'sd1 <<< (FRAC_BITS + 1);
   localparam longint      Q_FOUR_SQ     = 64'sd1 <<< (2 * FRAC_BITS + 2);
   localparam longint      Q_HALF        = 64'sd1 <<< (FRAC_BITS - 1);
   localparam longint      COORD_HI      = 64'sd2147483647;
   localparam longint      COORD_LO      = -64'sd2147483648;
   localparam int unsigned MAX_AT_RESET  = 255;
   localparam longint      C_RE_AT_RESET = -64'sd43594139;
   localparam longint      C_IM_AT_RESET = -64'sd32049486;
   localparam int          HOLD_CYCLES   = 600;
   localparam int          QUIET_LIMIT   = 20000;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          SWEEP_ROUNDS  = 40;
   localparam int          ROUND_POINTS  = 40;
   localparam int unsigned DEEP_CAP      = 300;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_im;
      logic signed [COORD_BITS-1:0] start_re;
   } point_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // start_re [31:0], start_im [63:32]
   logic [63:0]           req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // escape_count [15:0]
   logic [15:0]           rsp_tdata;
   logic                  csr_we;
   logic [jec_pkg::REG_IDX_W-1:0] csr_addr;
   logic [CSR_W-1:0]      csr_wdata;

   int unsigned           lim_iter;
   longint                c_re;
   longint                c_im;
   bit                    pow4;
   logic [COUNT_BITS-1:0] pending_counts[$];
   int                    error_count;
   int                    points_sent;
   int                    counts_checked;
   int unsigned           quiet_cycles;
   bit                    req_steady;
   bit                    rsp_steady;
   bit                    rsp_hold;

   julia_escape_count_unit #(
      .COUNT_BITS(COUNT_BITS),
      .COORD_BITS(COORD_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---- escape count prediction ----

   function automatic longint mul_q(longint a, longint b);
      return (a * b + Q_HALF) >>> FRAC_BITS;
   endfunction

   function automatic void square_q(input longint x, input longint y,
                                    output longint re, output longint im);
      re = mul_q(x, x) - mul_q(y, y);
      im = 2 * mul_q(x, y);
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
   endfunction

   function automatic bit outside_radius(longint x, longint y);
      if (x > Q_TWO || x < -Q_TWO || y > Q_TWO || y < -Q_TWO) return 1'b1;
      return x * x + y * y > Q_FOUR_SQ;
   endfunction

   function automatic int unsigned escape_steps(point_type p, int unsigned cap);
      longint      x;
      longint      y;
      longint      re;
      longint      im;
      int unsigned n;
      x = $signed(p.start_re);
      y = $signed(p.start_im);
      n = 0;
      while (n < cap && !outside_radius(x, y)) begin
         square_q(x, y, re, im);
         if (pow4) square_q(re, im, re, im);
         x = clamp_coord(re + c_re);
         y = clamp_coord(im + c_im);
         n++;
      end
      return n;
   endfunction

   // ---- stimulus helpers ----

   function automatic point_type mk_point(longint re, longint im);
      point_type p;
      p.start_re = re[COORD_BITS-1:0];
      p.start_im = im[COORD_BITS-1:0];
      return p;
   endfunction

   function automatic point_type rand_point();
      longint re;
      longint im;
      case ($urandom_range(9))
         0: return {$urandom, $urandom};
         1: begin
            // hug the boundary |z| = 2 along one axis
            re = ($urandom_range(1) ? Q_TWO : -Q_TWO) + longint'($urandom_range(64)) - 32;
            im = longint'($urandom_range(33554432)) - 16777216;
            if ($urandom_range(1)) return mk_point(im, re);
            return mk_point(re, im);
         end
         default: begin
            re = longint'($urandom_range(268435456)) - Q_TWO;
            im = longint'($urandom_range(268435456)) - Q_TWO;
            return mk_point(re, im);
         end
      endcase
   endfunction

   function automatic int unsigned idle_len();
      return ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
   endfunction

   task automatic send_point(point_type p);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      pending_counts.push_back(COUNT_BITS'(escape_steps(p, lim_iter)));
      points_sent++;
      if (!req_steady && $urandom_range(3) == 0) begin
         gap = idle_len();
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(jec_pkg::reg_idx_type idx, logic [CSR_W-1:0] val);
      longint v;
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      v = $signed(val);
      case (idx)
         jec_pkg::REG_MAX_ITER:   lim_iter = val[COUNT_BITS-1:0];
         jec_pkg::REG_C_REAL:     if (v >= -Q_TWO && v <= Q_TWO) c_re = v;
         jec_pkg::REG_C_IMAG:     if (v >= -Q_TWO && v <= Q_TWO) c_im = v;
         jec_pkg::REG_POWER_MODE: pow4 = val[0];
      endcase
      @(posedge clock);
   endtask

   // ---- response side ----

   initial begin : rsp_side
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!rsp_steady && $urandom_range(3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (idle_len()) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : count_check
      logic [COUNT_BITS-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_counts.size() == 0) begin
            $error("escape_count: no request pending, got %0d", rsp_tdata[COUNT_BITS-1:0]);
            error_count++;
         end else begin
            want = pending_counts.pop_front();
            counts_checked++;
            if (rsp_tdata[COUNT_BITS-1:0] !== want) begin
               $error("escape_count: expected %0d, got %0d", want,
                      rsp_tdata[COUNT_BITS-1:0]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d counts outstanding",
                  QUIET_LIMIT, pending_counts.size());
         $display("julia_escape_count_unit_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---- tests ----

   task automatic test_reset_defaults();
      req_steady = 1'b1;
      rsp_steady = 1'b1;
      send_point(mk_point(0, 0));
      send_point(mk_point(Q_TWO, 0));
      send_point(mk_point(Q_TWO + 1, 0));
      send_point(mk_point(0, -Q_TWO));
      send_point(mk_point(0, -Q_TWO - 1));
      send_point(mk_point(80530637, 107374182));
      send_point(mk_point(-80530637, -107374183));
      send_point(mk_point(COORD_HI, COORD_HI));
      send_point(mk_point(COORD_LO, COORD_LO));
      send_point(mk_point(COORD_LO, COORD_HI));
      // x*y lands exactly on a half lsb, positive and negative
      send_point(mk_point(4096, 8192));
      send_point(mk_point(-4096, 8192));
      wait_idle();
   endtask

   task automatic test_register_edges();
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      // zero limit, upper write bits set
      write_reg(jec_pkg::REG_MAX_ITER, {13'h1fff, 16'h0000});
      send_point(mk_point(0, 0));
      send_point(mk_point(Q_ONE / 2, -Q_ONE / 4));
      wait_idle();
      write_reg(jec_pkg::REG_MAX_ITER, 29'd255);
      write_reg(jec_pkg::REG_POWER_MODE, {28'hfffffff, 1'b1});
      send_point(mk_point(Q_ONE / 2, Q_ONE / 4));
      send_point(mk_point(0, 0));
      send_point(mk_point(-Q_ONE, Q_ONE / 8));
      wait_idle();
      // c at both extremes, then out-of-range values that must be dropped
      write_reg(jec_pkg::REG_C_REAL, CSR_W'(Q_TWO));
      write_reg(jec_pkg::REG_C_IMAG, CSR_W'(-Q_TWO));
      write_reg(jec_pkg::REG_C_REAL, CSR_W'(Q_TWO + 1));
      write_reg(jec_pkg::REG_C_IMAG, 29'h10000000);
      write_reg(jec_pkg::REG_MAX_ITER, 29'h0ffff);
      send_point(mk_point(0, 0));
      send_point(mk_point(Q_ONE / 3, -Q_ONE / 3));
      wait_idle();
      write_reg(jec_pkg::REG_POWER_MODE, 29'd0);
      send_point(mk_point(0, 0));
      send_point(mk_point(-Q_TWO, Q_TWO));
      wait_idle();
      // c = -2 keeps the origin bouncing on the radius forever
      write_reg(jec_pkg::REG_MAX_ITER, 29'd40);
      write_reg(jec_pkg::REG_C_REAL, CSR_W'(-Q_TWO));
      write_reg(jec_pkg::REG_C_IMAG, 29'd0);
      send_point(mk_point(0, 0));
      send_point(mk_point(-Q_TWO, 0));
      wait_idle();
      write_reg(jec_pkg::REG_C_REAL, CSR_W'(C_RE_AT_RESET));
      write_reg(jec_pkg::REG_C_IMAG, CSR_W'(C_IM_AT_RESET));
   endtask

   task automatic test_backpressure();
      write_reg(jec_pkg::REG_MAX_ITER, 29'd12);
      req_steady = 1'b1;
      rsp_steady = 1'b0;
      rsp_hold   = 1'b1;
      repeat (8) send_point(rand_point());
      wait_idle();
      req_steady = 1'b0;
      rsp_hold   = 1'b1;
      repeat (8) send_point(rand_point());
      wait_idle();
   endtask

   task automatic test_random_sweep();
      int          r;
      int          k;
      int unsigned pick;
      int unsigned m;
      longint      cv;
      point_type   p;
      for (r = 0; r < SWEEP_ROUNDS; r++) begin
         wait_idle();
         req_steady = ($urandom_range(4) == 0);
         rsp_steady = ($urandom_range(4) == 0);
         pick = $urandom_range(19);
         if (pick == 0) m = 0;
         else if (pick < 13) m = $urandom_range(32, 1);
         else if (pick < 18) m = $urandom_range(255, 33);
         else if (pick == 18) m = 65535;
         else m = $urandom_range(65535, 256);
         write_reg(jec_pkg::REG_MAX_ITER, {13'($urandom), m[15:0]});
         case ($urandom_range(3))
            0: begin
               write_reg(jec_pkg::REG_C_REAL, CSR_W'(C_RE_AT_RESET));
               write_reg(jec_pkg::REG_C_IMAG, CSR_W'(C_IM_AT_RESET));
            end
            1: begin
               cv = longint'($urandom_range(107374182)) - 53687091;
               write_reg(jec_pkg::REG_C_REAL, CSR_W'(cv));
               cv = longint'($urandom_range(107374182)) - 53687091;
               write_reg(jec_pkg::REG_C_IMAG, CSR_W'(cv));
            end
            2: begin
               cv = longint'($urandom_range(268435456)) - Q_TWO;
               write_reg(jec_pkg::REG_C_REAL, CSR_W'(cv));
               cv = longint'($urandom_range(268435456)) - Q_TWO;
               write_reg(jec_pkg::REG_C_IMAG, CSR_W'(cv));
            end
            default: begin
               // beyond plus or minus 2.0: dropped
               cv = longint'($urandom_range(402653183, 134217729));
               if ($urandom_range(1)) write_reg(jec_pkg::REG_C_REAL, CSR_W'(cv));
               else write_reg(jec_pkg::REG_C_IMAG, CSR_W'(cv));
            end
         endcase
         write_reg(jec_pkg::REG_POWER_MODE, {28'($urandom), 1'($urandom_range(1))});
         for (k = 0; k < ROUND_POINTS; k++) begin
            p = rand_point();
            // keep huge limits affordable: swap deep orbits for a far point
            if (lim_iter > DEEP_CAP && escape_steps(p, DEEP_CAP + 1) > DEEP_CAP)
               p = mk_point(COORD_HI, $signed(p.start_im));
            send_point(p);
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      lim_iter   = MAX_AT_RESET;
      c_re       = C_RE_AT_RESET;
      c_im       = C_IM_AT_RESET;
      pow4       = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_edges();
      test_backpressure();
      test_random_sweep();
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d start points sent, %0d escape counts compared", points_sent,
               counts_checked);
      $display("limits 0 to 65535, both power modes, c across +/-2.0, stalls on both sides");
      if (error_count == 0) $display("julia_escape_count_unit_tb: done, clean");
      else $display("julia_escape_count_unit_tb: done, errors");
      $finish;
   end

endmodule

// ===== julia_escape_count_unit.f =====
rtl/jec_pkg.sv
rtl/jec_mul.sv
rtl/julia_escape_count_unit.sv
rtl/jec_checker.sv
tb/julia_escape_count_unit_tb.sv
